// ===== hdl/aodr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and widths for the box overlap and side resolve block.
// Used by aodr_edge and aabb_overlap_direction_resolve_top.
package aodr_pkg;

  localparam int POS_W  = 32;
  localparam int EXT_W  = 31;
  localparam int PIV_W  = 17;
  localparam int PROD_W = EXT_W + PIV_W;
  localparam int EDGE_W = PROD_W + 2;
  localparam int DIFF_W = EDGE_W + 2;
  localparam int SUM_W  = EXT_W + 1;
  localparam int MUL_W  = SUM_W + EXT_W;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  typedef struct packed {
    logic prod;
    logic edge_sub;
  } edge_en_t;

endpackage

// ===== hdl/aabb_overlap_direction_resolve_top.sv =====
`timescale 1ns / 1ps
// Box pair overlap test with side choice and push-out vector.
// Depends on aodr_pkg and aodr_edge.
//
// Usage:
//   Input channel in_valid / in_stall carries one box pair per beat: position,
//   scaled extent and pivot for the own box and for the other box.
//   Output channel out_valid / out_stall carries one result beat per input
//   beat, in order: colliding, direction (left, right, down, up) and the
//   saturated push vector that separates the own box.
//   A beat is taken at a rising edge with valid high and stall low.
//   Throughput is one pair per cycle while out_stall is low; the depth is
//   set by the pivot multipliers, the edge and centre subtractions, and the
//   32 by 31 bit side cross products.
//   Each stage holds while the stage ahead is full and holding, so empty
//   stages keep filling while out_stall is high; in_stall rises only once
//   every stage is full. Nothing is dropped or repeated under stall.
//   Reset (rst, synchronous, active high) empties the pipeline; out_valid is
//   low in the cycle after reset and input is taken right away.
module aabb_overlap_direction_resolve_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] self_pos_x,
  input  logic [31:0] self_pos_y,
  input  logic [30:0] self_width,
  input  logic [30:0] self_height,
  input  logic [16:0] self_pivot_x,
  input  logic [16:0] self_pivot_y,
  input  logic [31:0] other_pos_x,
  input  logic [31:0] other_pos_y,
  input  logic [30:0] other_width,
  input  logic [30:0] other_height,
  input  logic [16:0] other_pivot_x,
  input  logic [16:0] other_pivot_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        colliding,
  output logic [1:0]  direction,
  output logic [31:0] push_x,
  output logic [31:0] push_y
);

  localparam int NST  = 6;
  localparam int EW   = aodr_pkg::EDGE_W;
  localparam int DW   = aodr_pkg::DIFF_W;
  localparam int XW   = aodr_pkg::EXT_W;
  localparam int SW   = aodr_pkg::SUM_W;
  localparam int MW   = aodr_pkg::MUL_W;

  logic [NST:1] vld;
  logic [NST:1] en;
  aodr_pkg::edge_en_t edge_en;

  // extents carried beside the edge units
  logic [XW-1:0] aw1, ah1, bw1, bh1, aw2, ah2, bw2, bh2;
  logic [EW-1:0] al, ab, bl, bb;

  // stage 3
  logic signed [DW-1:0] dx, dy, plx, prx, pdy, puy;
  logic [SW-1:0]        sx, sy;
  logic [XW-1:0]        bw3, bh3;
  // stage 4
  logic                 hit4, dxp4, dyp4;
  logic [SW-1:0]        mx4, my4;
  logic [XW-1:0]        bw4, bh4;
  logic signed [DW-1:0] plx4, prx4, pdy4, puy4;
  // stage 5
  logic                 hit5, dxp5, dyp5;
  logic [MW-1:0]        cx5, cy5;
  logic signed [DW-1:0] plx5, prx5, pdy5, puy5;

  function automatic logic signed [DW-1:0] sext_edge(input logic [EW-1:0] e);
    return {{(DW - EW){e[EW-1]}}, e};
  endfunction

  function automatic logic signed [DW-1:0] zext_ext(input logic [XW-1:0] e);
    return {{(DW - XW){1'b0}}, e};
  endfunction

  function automatic logic [31:0] sat32(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] hi;
    logic signed [DW-1:0] lo;
    hi = {{(DW - 31){1'b0}}, {31{1'b1}}};
    lo = {{(DW - 31){1'b1}}, {31{1'b0}}};
    if (v > hi) begin
      return 32'h7fff_ffff;
    end else if (v < lo) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  // advance a stage when it is empty or the stage ahead advances
  always_comb begin
    en[NST] = !vld[NST] || !out_stall;
    for (int k = NST - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
    edge_en.prod     = en[1];
    edge_en.edge_sub = en[2];
  end

  assign in_stall = !en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= NST; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  aodr_edge #(.FRAC_BITS(FRAC_BITS)) u_edge_al (
    .clk(clk), .en(edge_en), .pos(self_pos_x), .extent(self_width),
    .pivot(self_pivot_x), .edge_pos(al)
  );
  aodr_edge #(.FRAC_BITS(FRAC_BITS)) u_edge_ab (
    .clk(clk), .en(edge_en), .pos(self_pos_y), .extent(self_height),
    .pivot(self_pivot_y), .edge_pos(ab)
  );
  aodr_edge #(.FRAC_BITS(FRAC_BITS)) u_edge_bl (
    .clk(clk), .en(edge_en), .pos(other_pos_x), .extent(other_width),
    .pivot(other_pivot_x), .edge_pos(bl)
  );
  aodr_edge #(.FRAC_BITS(FRAC_BITS)) u_edge_bb (
    .clk(clk), .en(edge_en), .pos(other_pos_y), .extent(other_height),
    .pivot(other_pivot_y), .edge_pos(bb)
  );

  always_ff @(posedge clk) begin
    if (en[1]) begin
      aw1 <= self_width;
      ah1 <= self_height;
      bw1 <= other_width;
      bh1 <= other_height;
    end
    if (en[2]) begin
      aw2 <= aw1;
      ah2 <= ah1;
      bw2 <= bw1;
      bh2 <= bh1;
    end
  end

  // stage 3: doubled centre differences, extent sums, push candidates
  always_ff @(posedge clk) begin
    if (en[3]) begin
      dx  <= ((sext_edge(al) <<< 1) + zext_ext(aw2)) - ((sext_edge(bl) <<< 1) + zext_ext(bw2));
      dy  <= ((sext_edge(ab) <<< 1) + zext_ext(ah2)) - ((sext_edge(bb) <<< 1) + zext_ext(bh2));
      sx  <= SW'(aw2) + SW'(bw2);
      sy  <= SW'(ah2) + SW'(bh2);
      plx <= (sext_edge(bl) + zext_ext(bw2)) - sext_edge(al);
      prx <= sext_edge(bl) - (sext_edge(al) + zext_ext(aw2));
      pdy <= (sext_edge(bb) + zext_ext(bh2)) - sext_edge(ab);
      puy <= sext_edge(bb) - (sext_edge(ab) + zext_ext(ah2));
      bw3 <= bw2;
      bh3 <= bh2;
    end
  end

  // stage 4: magnitudes and overlap
  logic [DW-1:0] mx, my;
  always_comb begin
    mx = dx[DW-1] ? DW'(-dx) : DW'(dx);
    my = dy[DW-1] ? DW'(-dy) : DW'(dy);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      hit4 <= (mx <= DW'(sx)) && (my <= DW'(sy));
      dxp4 <= !dx[DW-1] && (dx != '0);
      dyp4 <= !dy[DW-1] && (dy != '0);
      mx4  <= mx[SW-1:0];
      my4  <= my[SW-1:0];
      bw4  <= bw3;
      bh4  <= bh3;
      plx4 <= plx;
      prx4 <= prx;
      pdy4 <= pdy;
      puy4 <= puy;
    end
  end

  // stage 5: side cross products
  always_ff @(posedge clk) begin
    if (en[5]) begin
      cx5  <= MW'(mx4) * MW'(bh4);
      cy5  <= MW'(my4) * MW'(bw4);
      hit5 <= hit4;
      dxp5 <= dxp4;
      dyp5 <= dyp4;
      plx5 <= plx4;
      prx5 <= prx4;
      pdy5 <= pdy4;
      puy5 <= puy4;
    end
  end

  // stage 6: side choice, push select and saturation into the output register
  aodr_pkg::dir_t dir;
  logic           xaxis;
  logic [31:0]    px_next, py_next;

  always_comb begin
    xaxis   = cx5 > cy5;
    px_next = '0;
    py_next = '0;
    if (xaxis) begin
      dir = dxp5 ? aodr_pkg::DIR_LEFT : aodr_pkg::DIR_RIGHT;
    end else begin
      dir = dyp5 ? aodr_pkg::DIR_DOWN : aodr_pkg::DIR_UP;
    end
    case (dir)
      aodr_pkg::DIR_LEFT:  px_next = sat32(plx5);
      aodr_pkg::DIR_RIGHT: px_next = sat32(prx5);
      aodr_pkg::DIR_DOWN:  py_next = sat32(pdy5);
      default:             py_next = sat32(puy5);
    endcase
    if (!hit5) begin
      dir     = aodr_pkg::DIR_LEFT;
      px_next = '0;
      py_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      colliding <= hit5;
      direction <= dir;
      push_x    <= px_next;
      push_y    <= py_next;
    end
  end

  assign out_valid = vld[NST];

endmodule

// ===== hdl/aodr_edge.sv =====
`timescale 1ns / 1ps
// Two-stage rectangle edge unit: pivot times extent, then position minus the
// truncated product. Depends on aodr_pkg for widths and the stage enables.
module aodr_edge #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  aodr_pkg::edge_en_t            en,
  input  logic [aodr_pkg::POS_W-1:0]    pos,
  input  logic [aodr_pkg::EXT_W-1:0]    extent,
  input  logic [aodr_pkg::PIV_W-1:0]    pivot,
  output logic [aodr_pkg::EDGE_W-1:0]   edge_pos
);

  logic [aodr_pkg::PROD_W-1:0] prod;
  logic [aodr_pkg::POS_W-1:0]  pos_d;
  logic [aodr_pkg::PROD_W-1:0] off;
  logic [aodr_pkg::EDGE_W-1:0] edge_next;

  always_ff @(posedge clk) begin
    if (en.prod) begin
      prod  <= aodr_pkg::PROD_W'(extent) * aodr_pkg::PROD_W'(pivot);
      pos_d <= pos;
    end
  end

  always_comb begin
    off       = prod >> FRAC_BITS;
    edge_next = {{(aodr_pkg::EDGE_W - aodr_pkg::POS_W){pos_d[aodr_pkg::POS_W-1]}}, pos_d}
                - {2'b00, off};
  end

  always_ff @(posedge clk) begin
    if (en.edge_sub) begin
      edge_pos <= edge_next;
    end
  end

endmodule

// ===== verif/aodr_check.sv =====
`timescale 1ns / 1ps
// Checker for the box overlap and side resolve block: predicts each result beat
// from the accepted input beat and compares it with the output channel.
// Depends on aodr_pkg for the direction type.
module aodr_check #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] self_pos_x,
  input  logic [31:0] self_pos_y,
  input  logic [30:0] self_width,
  input  logic [30:0] self_height,
  input  logic [16:0] self_pivot_x,
  input  logic [16:0] self_pivot_y,
  input  logic [31:0] other_pos_x,
  input  logic [31:0] other_pos_y,
  input  logic [30:0] other_width,
  input  logic [30:0] other_height,
  input  logic [16:0] other_pivot_x,
  input  logic [16:0] other_pivot_y,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        colliding,
  input  logic [1:0]  direction,
  input  logic [31:0] push_x,
  input  logic [31:0] push_y,
  output int          error_count,
  output int          results_due
);

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic           hit;
    aodr_pkg::dir_t dir;
    logic [31:0]    px;
    logic [31:0]    py;
  } box_result_t;

  box_result_t due_results[$];

  function automatic longint edge_at(input logic [31:0] pos, input logic [30:0] ext,
                                     input logic [16:0] piv);
    u64_t   off;
    longint base;
    off = (u64_t'(ext) * u64_t'(piv)) >> FRAC_BITS;
    base = longint'(signed'(pos));
    return base - longint'(off);
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > longint'(32'sh7fffffff)) return 32'h7fffffff;
    if (v < -longint'(64'h80000000)) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic box_result_t resolve_pair(
    input logic [31:0] spx, input logic [31:0] spy, input logic [30:0] sw,
    input logic [30:0] sh, input logic [16:0] svx, input logic [16:0] svy,
    input logic [31:0] opx, input logic [31:0] opy, input logic [30:0] ow,
    input logic [30:0] oh, input logic [16:0] ovx, input logic [16:0] ovy);
    longint      al, ab, bl, bb, aw, ah, bw, bh, dx, dy, px, py;
    u64_t        mx, my;
    box_result_t r;
    aw = longint'(u64_t'(sw));
    ah = longint'(u64_t'(sh));
    bw = longint'(u64_t'(ow));
    bh = longint'(u64_t'(oh));
    al = edge_at(spx, sw, svx);
    ab = edge_at(spy, sh, svy);
    bl = edge_at(opx, ow, ovx);
    bb = edge_at(opy, oh, ovy);
    dx = (2 * al + aw) - (2 * bl + bw);
    dy = (2 * ab + ah) - (2 * bb + bh);
    mx = (dx < 0) ? u64_t'(-dx) : u64_t'(dx);
    my = (dy < 0) ? u64_t'(-dy) : u64_t'(dy);
    px = 0;
    py = 0;
    r.hit = 1'b0;
    r.dir = aodr_pkg::DIR_LEFT;
    if (mx <= u64_t'(aw + bw) && my <= u64_t'(ah + bh)) begin
      r.hit = 1'b1;
      if (mx * u64_t'(bh) > my * u64_t'(bw)) begin
        if (dx > 0) r.dir = aodr_pkg::DIR_LEFT;
        else r.dir = aodr_pkg::DIR_RIGHT;
      end else begin
        if (dy > 0) r.dir = aodr_pkg::DIR_DOWN;
        else r.dir = aodr_pkg::DIR_UP;
      end
      case (r.dir)
        aodr_pkg::DIR_LEFT:  px = bl + bw - al;
        aodr_pkg::DIR_RIGHT: px = bl - (al + aw);
        aodr_pkg::DIR_DOWN:  py = bb + bh - ab;
        default:             py = bb - (ab + ah);
      endcase
    end
    r.px = clamp32(px);
    r.py = clamp32(py);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: %s expected %h got %h", $time, what, want, got);
    error_count++;
  endtask

  always @(posedge clk) begin
    box_result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        due_results.push_back(resolve_pair(self_pos_x, self_pos_y, self_width, self_height,
                                           self_pivot_x, self_pivot_y, other_pos_x,
                                           other_pos_y, other_width, other_height,
                                           other_pivot_x, other_pivot_y));
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: result beat with nothing due: colliding %b direction %0d push %h %h",
                   $time, colliding, direction, push_x, push_y);
          error_count++;
        end else begin
          want = due_results.pop_front();
          if (colliding !== want.hit)
            report_mismatch("colliding", 32'(want.hit), 32'(colliding));
          if (direction !== want.dir)
            report_mismatch("direction", 32'(want.dir), 32'(direction));
          if (push_x !== want.px) report_mismatch("push_x", want.px, push_x);
          if (push_y !== want.py) report_mismatch("push_y", want.py, push_y);
        end
      end
    end
    results_due <= due_results.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for aabb_overlap_direction_resolve_top: drives directed and random
// box pairs with random gaps and back pressure, and gives the verdict.
// Depends on aodr_pkg, the block under test and aodr_check.
module tb;

  localparam int ONE   = 65536;
  localparam int HALF  = 32768;
  localparam int HOLD  = 200;
  localparam int LIMIT = 200000;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [30:0] w;
    logic [30:0] h;
    logic [16:0] piv_x;
    logic [16:0] piv_y;
  } box_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        out_stall = 1'b0;
  box_t        self_box = '0;
  box_t        other_box = '0;
  logic        in_stall;
  logic        out_valid;
  logic        colliding;
  logic [1:0]  direction;
  logic [31:0] push_x;
  logic [31:0] push_y;
  int          error_count;
  int          results_due;

  int unsigned snd_idle = 11;
  int unsigned rcv_idle = 77;
  bit          start_hold = 1'b0;
  bit          held = 1'b0;
  int          hold_cnt = 0;
  int          cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  aabb_overlap_direction_resolve_top uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .self_pos_x(self_box.pos_x), .self_pos_y(self_box.pos_y),
    .self_width(self_box.w), .self_height(self_box.h),
    .self_pivot_x(self_box.piv_x), .self_pivot_y(self_box.piv_y),
    .other_pos_x(other_box.pos_x), .other_pos_y(other_box.pos_y),
    .other_width(other_box.w), .other_height(other_box.h),
    .other_pivot_x(other_box.piv_x), .other_pivot_y(other_box.piv_y),
    .out_valid(out_valid), .out_stall(out_stall), .colliding(colliding),
    .direction(direction), .push_x(push_x), .push_y(push_y)
  );

  aodr_check chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .self_pos_x(self_box.pos_x), .self_pos_y(self_box.pos_y),
    .self_width(self_box.w), .self_height(self_box.h),
    .self_pivot_x(self_box.piv_x), .self_pivot_y(self_box.piv_y),
    .other_pos_x(other_box.pos_x), .other_pos_y(other_box.pos_y),
    .other_width(other_box.w), .other_height(other_box.h),
    .other_pivot_x(other_box.piv_x), .other_pivot_y(other_box.piv_y),
    .out_valid(out_valid), .out_stall(out_stall), .colliding(colliding),
    .direction(direction), .push_x(push_x), .push_y(push_y),
    .error_count(error_count), .results_due(results_due)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stall, or one long hold-off on request
  initial forever begin
    @(posedge clk);
    if (start_hold && !held) begin
      held = 1'b1;
      hold_cnt = HOLD;
    end
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_idle);
    end
  end

  function automatic box_t mk(input logic [31:0] px, input logic [31:0] py,
                              input logic [30:0] w, input logic [30:0] h,
                              input logic [16:0] vx, input logic [16:0] vy);
    box_t b;
    b.pos_x = px;
    b.pos_y = py;
    b.w = w;
    b.h = h;
    b.piv_x = vx;
    b.piv_y = vy;
    return b;
  endfunction

  function automatic logic [30:0] rand_ext(input int unsigned sc);
    if ($urandom_range(0, 15) == 0) return '0;
    if (sc < 6) return 31'($urandom_range(0, 1 << 18));
    if (sc < 9) return 31'($urandom_range(0, 1 << 26));
    return 31'($urandom());
  endfunction

  function automatic logic [16:0] rand_pivot();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 17'd65536;
      2:       return 17'($urandom());
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic offer(input box_t s, input box_t o);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    self_box <= s;
    other_box <= o;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // mostly pairs placed close together so that overlap and every side occur
  task automatic make_pair(output box_t s, output box_t o);
    int unsigned mode, sc;
    longint      span_x, span_y, off_x, off_y;
    mode = $urandom_range(0, 19);
    sc = $urandom_range(0, 9);
    o = mk($urandom(), $urandom(), rand_ext(sc), rand_ext(sc), rand_pivot(), rand_pivot());
    s = mk($urandom(), $urandom(), rand_ext(sc), rand_ext(sc), rand_pivot(), rand_pivot());
    if (mode < 2) begin
      s = mk($urandom(), $urandom(), 31'($urandom()), 31'($urandom()),
             17'($urandom()), 17'($urandom()));
    end else if (mode == 2) begin
      s = o;
    end else begin
      if (mode < 12) begin
        s.piv_x = o.piv_x;
        s.piv_y = o.piv_y;
      end
      span_x = longint'(s.w) + longint'(o.w) + 2;
      span_y = longint'(s.h) + longint'(o.h) + 2;
      off_x = longint'($urandom()) % span_x - span_x / 2;
      off_y = longint'($urandom()) % span_y - span_y / 2;
      s.pos_x = o.pos_x + off_x[31:0];
      s.pos_y = o.pos_y + off_y[31:0];
    end
  endtask

  task automatic run_random(input int n);
    box_t s, o;
    repeat (n) begin
      make_pair(s, o);
      offer(s, o);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    offer(mk(0, 0, 0, 0, 0, 0), mk(0, 0, 0, 0, 0, 0));
    offer(mk(0, 0, ONE, ONE, HALF, HALF), mk(0, 0, ONE, ONE, HALF, HALF));
    offer(mk(3 * ONE, 0, ONE, ONE, HALF, HALF), mk(0, 0, ONE, ONE, HALF, HALF));
    offer(mk(0, -3 * ONE, ONE, ONE, HALF, HALF), mk(0, 0, ONE, ONE, HALF, HALF));
    offer(mk(ONE, 0, ONE, ONE, HALF, HALF), mk(0, 0, ONE, ONE, HALF, HALF));
    offer(mk(ONE / 2, ONE / 8, ONE, ONE, HALF, HALF), mk(0, 0, ONE, ONE, HALF, HALF));
    offer(mk(-ONE / 2, ONE / 8, ONE, ONE, HALF, HALF), mk(0, 0, ONE, ONE, HALF, HALF));
    offer(mk(ONE / 8, ONE / 2, ONE, ONE, HALF, HALF), mk(0, 0, ONE, ONE, HALF, HALF));
    offer(mk(ONE / 8, -ONE / 2, ONE, ONE, HALF, HALF), mk(0, 0, ONE, ONE, HALF, HALF));
    offer(mk(ONE / 2, ONE / 2, ONE, ONE, HALF, HALF), mk(0, 0, ONE, ONE, HALF, HALF));
    offer(mk(ONE / 4, 0, ONE, ONE, HALF, HALF), mk(0, 0, 0, ONE, HALF, HALF));
    offer(mk(ONE / 4, ONE / 4, ONE, ONE, HALF, HALF), mk(0, 0, 0, 0, 0, 0));
    offer(mk(0, 0, ONE, ONE, 17'h1ffff, 17'h1ffff), mk(0, 0, ONE, ONE, 0, 0));
    offer(mk(0, 0, ONE, ONE, 17'd65536, 17'd65536), mk(-ONE / 2, 0, ONE, ONE, 0, 0));
    offer(mk(32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 31'h7fffffff, 0, 0),
          mk(32'h80000000, 32'h80000000, 31'h7fffffff, 31'h7fffffff, 17'h1ffff, 17'h1ffff));
    offer(mk(32'h80000000, 32'h80000000, 31'h7fffffff, 31'h7fffffff, 17'h1ffff, 17'h1ffff),
          mk(32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 31'h7fffffff, 0, 0));
    offer(mk(32'h7fffffff, 0, 31'h7fffffff, 31'h7fffffff, 0, 0),
          mk(32'h7fffffff, 0, 31'h7fffffff, 31'h7fffffff, 17'h1ffff, 17'h1ffff));
    offer(mk(0, 0, 31'h7fffffff, 31'h7fffffff, HALF, HALF),
          mk(ONE, -ONE, 31'h7fffffff, 31'h7fffffff, HALF, HALF));
    offer(mk(32'h80000000, 32'h7fffffff, 0, 0, 0, 0),
          mk(32'h7fffffff, 32'h80000000, 0, 0, 17'h1ffff, 17'h1ffff));
    run_random(420);

    snd_idle = 77;
    rcv_idle = 11;
    run_random(420);
    // pause until every result is out
    drain();

    snd_idle = 0;
    rcv_idle = 0;
    start_hold = 1'b1;
    run_random(420);

    drain();
    repeat (12) @(posedge clk);
    if (error_count == 0 && results_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/aodr_pkg.sv
hdl/aodr_edge.sv
hdl/aabb_overlap_direction_resolve_top.sv
verif/aodr_check.sv
verif/tb.sv
